[sv/cbs_pkg.sv]
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the body signal controller: frame ids,
// decoded command codes, the command word that crosses the queue and the
// result word.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// button / frame event codes
	typedef enum logic [2:0] {
		ACT_FRAME = 3'd0,
		ACT_LEFT  = 3'd1,
		ACT_RIGHT = 3'd2,
		ACT_LOW   = 3'd3,
		ACT_HIGH  = 3'd4,
		ACT_AUTO  = 3'd5
	} action_t;

	// CAN identifiers (standard 11-bit range)
	localparam logic [10:0] ID_GEAR   = 11'h100;
	localparam logic [10:0] ID_SPEED  = 11'h101;
	localparam logic [10:0] ID_LIGHT  = 11'h102;
	localparam logic [10:0] ID_TEMP   = 11'h103;
	localparam logic [10:0] ID_HUM    = 11'h104;
	localparam logic [10:0] ID_DIST   = 11'h105;
	localparam logic [10:0] ID_BUZZ   = 11'h106;
	localparam logic [10:0] ID_BUZZ_TX = 11'h200;
	localparam logic [10:0] ID_LAMP   = 11'h201;

	// configuration register indexes
	localparam logic [2:0] CFG_LIGHT_DARK = 3'd0;
	localparam logic [2:0] CFG_HIGH_SPEED = 3'd1;
	localparam logic [2:0] CFG_DIST_OFF   = 3'd2;
	localparam logic [2:0] CFG_DIST_LOW   = 3'd3;
	localparam logic [2:0] CFG_DIST_MID   = 3'd4;

	// headlight codes
	localparam logic [1:0] HL_OFF  = 2'd0;
	localparam logic [1:0] HL_LOW  = 2'd1;
	localparam logic [1:0] HL_HIGH = 2'd2;

	// buzzer levels
	localparam logic [1:0] BZ_OFF  = 2'd0;
	localparam logic [1:0] BZ_LOW  = 2'd1;
	localparam logic [1:0] BZ_MID  = 2'd2;
	localparam logic [1:0] BZ_HIGH = 2'd3;

	localparam logic [7:0] GEAR_REVERSE = 8'd1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_GEAR,
		OP_SPEED,
		OP_LIGHT,
		OP_TEMP,
		OP_HUM,
		OP_DIST,
		OP_BUZZ,
		OP_LAMP,
		OP_LEFT,
		OP_RIGHT,
		OP_LOW,
		OP_HIGH,
		OP_AUTO
	} op_t;

	// data holds {byte_zero, byte_one}
	typedef struct packed {
		op_t         op;
		logic [15:0] data;
	} cmd_t;

	typedef struct packed {
		logic        tx_valid;
		logic [10:0] tx_id;
		logic [7:0]  tx_byte;
		logic [7:0]  gear;
		logic [15:0] speed;
		logic [7:0]  light;
		logic [15:0] temp;
		logic [7:0]  humidity;
		logic [15:0] distance;
		logic [1:0]  buzzer;
		logic [3:0]  lamp;
		logic        auto_on;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

[sv/can_body_signal_controller.sv]
// ----------------------------------------------------------------------------
// can_body_signal_controller
// Vehicle body node: decodes CAN frames and button events into stored
// signals, drives the reverse buzzer and headlights, emits tx frames.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) carries one event per transaction:
//  a received frame (action 0 with id, length and two bytes) or a button
//  toggle. Output channel (out_valid / out_stall) returns exactly one
//  result per event: the optional tx frame (tx_valid, tx_id, tx_byte)
//  plus a snapshot of all stored signals after the event.
//  Config port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//  light, speed and distance limits; cfg_ready is always high. Write it
//  only while no event is in flight.
//  An input transaction passes through the command queue and then the
//  execute/output register. Throughput: one event per cycle while
//  out_stall is low; the execute stage updates all state as it takes
//  each command, so the state feedback loop sets no extra limit.
//  Reset: all signals return to their defaults (temperature 250 tenths,
//  humidity 80, the rest zero), limits to their reset values, queue empty.
//  Receiver stall: the result register holds; the 4-entry command queue
//  keeps taking events until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module can_body_signal_controller (
	input  logic        clk,
	input  logic        arst_n,
	// event input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [28:0] frame_id,
	input  logic [3:0]  frame_len,
	input  logic [7:0]  byte_zero,
	input  logic [7:0]  byte_one,
	// config write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [10:0] tx_id,
	output logic [7:0]  tx_byte,
	output logic [7:0]  gear_now,
	output logic [15:0] speed_now,
	output logic [7:0]  light_now,
	output logic [15:0] temp_tenths,
	output logic [7:0]  humidity_now,
	output logic [15:0] distance_now,
	output logic [1:0]  buzzer_level,
	output logic [3:0]  lamp_bits,
	output logic        auto_on
);

	cbs_pkg::cmd_t    front_cmd;
	cbs_pkg::cmd_t    head_cmd;
	cbs_pkg::cfg_wr_t cfg_wr;
	cbs_pkg::result_t res;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;

	// config always accepted
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// input stalls only on a full queue
	assign in_stall = q_full;

	cbs_front u_front (
		.action    (action),
		.frame_id  (frame_id),
		.frame_len (frame_len),
		.byte_zero (byte_zero),
		.byte_one  (byte_one),
		.cmd       (front_cmd)
	);

	cbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	cbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.cfg_wr    (cfg_wr),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (res)
	);

	// unpack result word onto the output fields
	assign tx_valid     = res.tx_valid;
	assign tx_id        = res.tx_id;
	assign tx_byte      = res.tx_byte;
	assign gear_now     = res.gear;
	assign speed_now    = res.speed;
	assign light_now    = res.light;
	assign temp_tenths  = res.temp;
	assign humidity_now = res.humidity;
	assign distance_now = res.distance;
	assign buzzer_level = res.buzzer;
	assign lamp_bits    = res.lamp;
	assign auto_on      = res.auto_on;

endmodule

[sv/cbs_front.sv]
// ----------------------------------------------------------------------------
// cbs_front
// Classifies an incoming event into a command: frame id match and length
// check, button code mapping.
// ----------------------------------------------------------------------------
module cbs_front (
	input  logic [2:0]   action,
	input  logic [28:0]  frame_id,
	input  logic [3:0]   frame_len,
	input  logic [7:0]   byte_zero,
	input  logic [7:0]   byte_one,
	output cbs_pkg::cmd_t cmd
);

	logic std_id;
	logic len1;
	logic len2;

	assign std_id = (frame_id[28:11] == '0);
	assign len1   = (frame_len != 4'd0);
	assign len2   = (frame_len > 4'd1);

	always_comb begin
		cmd.op   = cbs_pkg::OP_NONE;
		cmd.data = {byte_zero, byte_one};
		unique case (cbs_pkg::action_t'(action))
			cbs_pkg::ACT_FRAME: begin
				if (std_id) begin
					unique case (frame_id[10:0])
						cbs_pkg::ID_GEAR:  if (len1) cmd.op = cbs_pkg::OP_GEAR;
						cbs_pkg::ID_SPEED: if (len2) cmd.op = cbs_pkg::OP_SPEED;
						cbs_pkg::ID_LIGHT: if (len1) cmd.op = cbs_pkg::OP_LIGHT;
						cbs_pkg::ID_TEMP:  if (len2) cmd.op = cbs_pkg::OP_TEMP;
						cbs_pkg::ID_HUM:   if (len1) cmd.op = cbs_pkg::OP_HUM;
						cbs_pkg::ID_DIST:  if (len2) cmd.op = cbs_pkg::OP_DIST;
						cbs_pkg::ID_BUZZ:  if (len1) cmd.op = cbs_pkg::OP_BUZZ;
						cbs_pkg::ID_LAMP:  if (len1) cmd.op = cbs_pkg::OP_LAMP;
						default:           cmd.op = cbs_pkg::OP_NONE;
					endcase
				end
			end
			cbs_pkg::ACT_LEFT:  cmd.op = cbs_pkg::OP_LEFT;
			cbs_pkg::ACT_RIGHT: cmd.op = cbs_pkg::OP_RIGHT;
			cbs_pkg::ACT_LOW:   cmd.op = cbs_pkg::OP_LOW;
			cbs_pkg::ACT_HIGH:  cmd.op = cbs_pkg::OP_HIGH;
			cbs_pkg::ACT_AUTO:  cmd.op = cbs_pkg::OP_AUTO;
			default:            cmd.op = cbs_pkg::OP_NONE;
		endcase
	end

endmodule

[sv/cbs_queue.sv]
// ----------------------------------------------------------------------------
// cbs_queue
// Small command FIFO between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module cbs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cbs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output cbs_pkg::cmd_t head_cmd
);

	cbs_pkg::cmd_t mem_q [cbs_pkg::QUEUE_DEPTH];
	logic [cbs_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [cbs_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [cbs_pkg::QUEUE_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full     = (count_q == cbs_pkg::QUEUE_CNT_W'(cbs_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/cbs_back.sv]
// ----------------------------------------------------------------------------
// cbs_back
// Executes one command per cycle while the result is not stalled, on the
// stored vehicle signals, derives the buzzer and auto headlight, and holds the result in the output register.
// ----------------------------------------------------------------------------
module cbs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cbs_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  cbs_pkg::cfg_wr_t cfg_wr,
	output logic             res_valid,
	input  logic             res_stall,
	output cbs_pkg::result_t res
);

	// configuration
	logic [7:0]  light_dark_q;
	logic [15:0] high_speed_q;
	logic [15:0] dist_off_q;
	logic [15:0] dist_low_q;
	logic [15:0] dist_mid_q;

	// vehicle state
	logic [7:0]  gear_q;
	logic [15:0] speed_q;
	logic [7:0]  light_q;
	logic [15:0] temp_q;
	logic [7:0]  hum_q;
	logic [15:0] dist_q;
	logic [1:0]  buzz_q;
	logic        left_q;
	logic        right_q;
	logic [1:0]  head_q;
	logic        auto_q;

	logic        res_valid_q;
	cbs_pkg::result_t res_q;

	logic [7:0]  nx_gear;
	logic [15:0] nx_speed;
	logic [7:0]  nx_light;
	logic [15:0] nx_temp;
	logic [7:0]  nx_hum;
	logic [15:0] nx_dist;
	logic [1:0]  nx_buzz;
	logic        nx_left;
	logic        nx_right;
	logic [1:0]  nx_head;
	logic        nx_auto;
	logic        buzz_chk;
	logic        head_chk;
	logic        lamp_tx;
	logic [1:0]  lvl;
	logic [1:0]  head_sel;
	logic [7:0]  b0;
	cbs_pkg::result_t nx_res;

	assign cmd_pop   = cmd_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign b0        = cmd.data[15:8];

	always_comb begin
		nx_gear  = gear_q;
		nx_speed = speed_q;
		nx_light = light_q;
		nx_temp  = temp_q;
		nx_hum   = hum_q;
		nx_dist  = dist_q;
		nx_buzz  = buzz_q;
		nx_left  = left_q;
		nx_right = right_q;
		nx_head  = head_q;
		nx_auto  = auto_q;
		buzz_chk = 1'b0;
		head_chk = 1'b0;
		lamp_tx  = 1'b0;
		unique case (cmd.op)
			cbs_pkg::OP_GEAR: begin
				if (b0 != gear_q) begin
					nx_gear  = b0;
					buzz_chk = 1'b1;
				end
			end
			cbs_pkg::OP_SPEED: begin
				if (cmd.data != speed_q) begin
					nx_speed = cmd.data;
					head_chk = 1'b1;
				end
			end
			cbs_pkg::OP_LIGHT: begin
				if (b0 != light_q) begin
					nx_light = b0;
					head_chk = 1'b1;
				end
			end
			cbs_pkg::OP_TEMP: nx_temp = cmd.data;
			cbs_pkg::OP_HUM:  nx_hum  = b0;
			cbs_pkg::OP_DIST: begin
				if (cmd.data != dist_q) begin
					nx_dist  = cmd.data;
					buzz_chk = 1'b1;
				end
			end
			cbs_pkg::OP_BUZZ: nx_buzz = b0[1:0];
			cbs_pkg::OP_LAMP: begin
				nx_left  = b0[0];
				nx_right = b0[1];
				nx_head  = b0[3:2];
			end
			cbs_pkg::OP_LEFT: begin
				if (!left_q) begin
					nx_left  = 1'b1;
					nx_right = 1'b0;
				end else begin
					nx_left = 1'b0;
				end
				lamp_tx = 1'b1;
			end
			cbs_pkg::OP_RIGHT: begin
				if (!right_q) begin
					nx_right = 1'b1;
					nx_left  = 1'b0;
				end else begin
					nx_right = 1'b0;
				end
				lamp_tx = 1'b1;
			end
			cbs_pkg::OP_LOW: begin
				nx_auto = 1'b0;
				nx_head = (head_q == cbs_pkg::HL_LOW) ? cbs_pkg::HL_OFF : cbs_pkg::HL_LOW;
				lamp_tx = 1'b1;
			end
			cbs_pkg::OP_HIGH: begin
				nx_auto = 1'b0;
				nx_head = (head_q == cbs_pkg::HL_HIGH) ? cbs_pkg::HL_OFF : cbs_pkg::HL_HIGH;
				lamp_tx = 1'b1;
			end
			cbs_pkg::OP_AUTO: begin
				nx_auto  = ~auto_q;
				head_chk = ~auto_q;
			end
			default: begin
			end
		endcase

		// buzzer level from reverse gear and obstacle distance
		if (nx_gear != cbs_pkg::GEAR_REVERSE) lvl = cbs_pkg::BZ_OFF;
		else if (nx_dist > dist_off_q)        lvl = cbs_pkg::BZ_OFF;
		else if (nx_dist > dist_low_q)        lvl = cbs_pkg::BZ_LOW;
		else if (nx_dist > dist_mid_q)        lvl = cbs_pkg::BZ_MID;
		else                                  lvl = cbs_pkg::BZ_HIGH;

		// auto headlight choice
		if (nx_light > light_dark_q)       head_sel = cbs_pkg::HL_OFF;
		else if (nx_speed <= high_speed_q) head_sel = cbs_pkg::HL_LOW;
		else                               head_sel = cbs_pkg::HL_HIGH;

		nx_res          = '0;
		if (buzz_chk && (lvl != buzz_q)) begin
			nx_buzz         = lvl;
			nx_res.tx_valid = 1'b1;
			nx_res.tx_id    = cbs_pkg::ID_BUZZ_TX;
			nx_res.tx_byte  = {6'b0, lvl};
		end
		if (head_chk && nx_auto && (head_sel != head_q)) begin
			nx_head = head_sel;
			lamp_tx = 1'b1;
		end
		if (lamp_tx) begin
			nx_res.tx_valid = 1'b1;
			nx_res.tx_id    = cbs_pkg::ID_LAMP;
			nx_res.tx_byte  = {4'b0, nx_head, nx_right, nx_left};
		end
		nx_res.gear     = nx_gear;
		nx_res.speed    = nx_speed;
		nx_res.light    = nx_light;
		nx_res.temp     = nx_temp;
		nx_res.humidity = nx_hum;
		nx_res.distance = nx_dist;
		nx_res.buzzer   = nx_buzz;
		nx_res.lamp     = {nx_head, nx_right, nx_left};
		nx_res.auto_on  = nx_auto;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_dark_q <= 8'd50;
			high_speed_q <= 16'd80;
			dist_off_q   <= 16'd50;
			dist_low_q   <= 16'd30;
			dist_mid_q   <= 16'd10;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				cbs_pkg::CFG_LIGHT_DARK: light_dark_q <= cfg_wr.data[7:0];
				cbs_pkg::CFG_HIGH_SPEED: high_speed_q <= cfg_wr.data;
				cbs_pkg::CFG_DIST_OFF:   dist_off_q   <= cfg_wr.data;
				cbs_pkg::CFG_DIST_LOW:   dist_low_q   <= cfg_wr.data;
				cbs_pkg::CFG_DIST_MID:   dist_mid_q   <= cfg_wr.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q      <= '0;
			speed_q     <= '0;
			light_q     <= '0;
			temp_q      <= 16'd250;
			hum_q       <= 8'd80;
			dist_q      <= '0;
			buzz_q      <= cbs_pkg::BZ_OFF;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			head_q      <= cbs_pkg::HL_OFF;
			auto_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				gear_q  <= nx_gear;
				speed_q <= nx_speed;
				light_q <= nx_light;
				temp_q  <= nx_temp;
				hum_q   <= nx_hum;
				dist_q  <= nx_dist;
				buzz_q  <= nx_buzz;
				left_q  <= nx_left;
				right_q <= nx_right;
				head_q  <= nx_head;
				auto_q  <= nx_auto;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q <= nx_res;
		end
	end

endmodule

[sv/cbs_checker.sv]
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks of the body signal controller result channel.
// ----------------------------------------------------------------------------
module cbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        tx_valid,
	input logic [10:0] tx_id,
	input logic [7:0]  tx_byte,
	input logic [1:0]  buzzer_level,
	input logic [3:0]  lamp_bits
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_id) && $stable(tx_byte)
			&& $stable(lamp_bits) && $stable(buzzer_level))
		else $error("stalled result changed");

	// no tx frame means zero id and byte
	a_idle_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_id == '0 && tx_byte == '0)
		else $error("tx fields set without tx frame");

	// only buzzer or lamp frames are sent
	a_tx_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> tx_id == cbs_pkg::ID_BUZZ_TX || tx_id == cbs_pkg::ID_LAMP)
		else $error("unexpected tx id");

	// buzzer frame carries the new level
	a_buzz_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid && tx_id == cbs_pkg::ID_BUZZ_TX
			|-> tx_byte == {6'b0, buzzer_level})
		else $error("buzzer frame disagrees with level");

	// lamp frame carries the new lamp word
	a_lamp_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid && tx_id == cbs_pkg::ID_LAMP
			|-> tx_byte == {4'b0, lamp_bits})
		else $error("lamp frame disagrees with lamp bits");

endmodule

bind can_body_signal_controller cbs_checker u_cbs_checker (.*);
